### src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while in reset
`define ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

### src/tte_pkg.sv
// types and constants of the text terminal escape engine
package tte_pkg;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_SCR_RD,
    S_SCR_WR,
    S_FILL,
    S_DONE
  } eng_state_t;

  // escape parser states
  typedef enum logic [3:0] {
    PS_START,
    PS_ESC,
    PS_BRACKET,
    PS_NUM1,
    PS_QUEST,
    PS_SEMI,
    PS_NUM2,
    PS_NUM3,
    PS_PAGE
  } parse_state_t;

  // cursor movement requested by a byte
  typedef enum logic [3:0] {
    CUR_NONE,
    CUR_LEFT,
    CUR_RIGHT,
    CUR_UP,
    CUR_DOWN,
    CUR_TAB,
    CUR_NEWLINE,
    CUR_CR,
    CUR_HOME,
    CUR_MOVE
  } cur_op_t;

  // buffer blanking requested by a byte
  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_LINE,
    FILL_SCREEN,
    FILL_ERASE
  } fill_op_t;

  // decoded action of one console byte
  typedef struct packed {
    parse_state_t next;
    logic         fn_we;
    logic [6:0]   fn_val;
    logic         sn_we;
    logic [7:0]   sn_val;
    logic         set_shown;
    logic         shown_val;
    logic         set_wrap;
    logic         wrap_val;
    cur_op_t      cur;
    fill_op_t     fill;
    logic         put;
    logic [7:0]   put_val;
  } dec_t;

  // configuration register indexes
  localparam int         CFG_IDX_W   = 2;
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;

  // screen size after reset
  localparam int COLS_RESET = 80;
  localparam int ROWS_RESET = 25;

  // tab stop spacing
  localparam int TAB_STEP = 8;

  // number field limits and the cursor show/hide mode number
  localparam logic [9:0]  NUM1_LIMIT = 10'd99;
  localparam logic [10:0] NUM2_LIMIT = 11'd199;
  localparam logic [6:0]  SHOW_MODE  = 7'd25;

  // byte codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;
  localparam logic [7:0] CH_HOME   = 8'h48;
  localparam logic [7:0] CH_CLR_J  = 8'h4A;
  localparam logic [7:0] CH_CLR_K  = 8'h4B;
  localparam logic [7:0] CH_ERASE  = 8'h58;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_PAGE   = 8'h64;
  localparam logic [7:0] CH_SHOW   = 8'h68;
  localparam logic [7:0] CH_HIDE   = 8'h6C;
  localparam logic [7:0] CH_GFX_LO = 8'h80;
  localparam logic [7:0] CH_GFX_HI = 8'h87;

endpackage

### src/tte_decode.sv
// escape parser: turns one console byte into an action
module tte_decode (
  input  tte_pkg::parse_state_t ps,
  input  logic [7:0]            c,
  input  logic [6:0]            first_num,
  input  logic [7:0]            second_num,
  output tte_pkg::dec_t         d
);
  import tte_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic [9:0]  fn_prod;
  logic [10:0] sn_prod;

  // digit test and decimal accumulation
  always_comb begin
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    digit    = c[3:0];
    fn_prod  = ({3'b000, first_num} << 3) + ({3'b000, first_num} << 1) + {6'b0, digit};
    sn_prod  = ({3'b000, second_num} << 3) + ({3'b000, second_num} << 1) + {7'b0, digit};
  end

  // per-state byte handling
  always_comb begin
    d       = '0;
    d.next  = PS_START;
    d.cur   = CUR_NONE;
    d.fill  = FILL_NONE;
    unique case (ps)
      PS_START: begin
        priority if (c == CH_BS) begin
          d.cur = CUR_LEFT;
        end else if (c == CH_TAB) begin
          d.cur = CUR_TAB;
        end else if (c == CH_LF) begin
          d.cur = CUR_NEWLINE;
        end else if (c == CH_CR) begin
          d.cur = CUR_CR;
        end else if (c == CH_ESC) begin
          d.next = PS_ESC;
        end else if (c >= CH_SPACE) begin
          d.put     = 1'b1;
          d.put_val = (c >= CH_GFX_LO && c <= CH_GFX_HI) ? {5'b0, c[2:0]} : c;
          d.cur     = CUR_RIGHT;
        end
      end
      PS_ESC: begin
        if (c == CH_LBRACK) d.next = PS_BRACKET;
        else if (c == CH_PAGE) d.next = PS_PAGE;
      end
      PS_BRACKET: begin
        priority if (c == CH_QUEST) begin
          d.next = PS_QUEST;
        end else if (c == CH_UP) begin
          d.cur = CUR_UP;
        end else if (c == CH_DOWN) begin
          d.cur = CUR_DOWN;
        end else if (c == CH_RIGHT) begin
          d.cur = CUR_RIGHT;
        end else if (c == CH_LEFT) begin
          d.cur = CUR_LEFT;
        end else if (c == CH_HOME) begin
          d.cur = CUR_HOME;
        end else if (c == CH_CLR_J) begin
          d.fill = FILL_SCREEN;
        end else if (c == CH_CLR_K) begin
          d.fill = FILL_LINE;
        end else if (is_digit) begin
          d.fn_we  = 1'b1;
          d.fn_val = {3'b000, digit};
          d.next   = PS_NUM1;
        end
      end
      PS_NUM1, PS_NUM3: begin
        priority if (ps == PS_NUM1 && c == CH_SEMI) begin
          d.next = PS_SEMI;
        end else if (ps == PS_NUM1 && c == CH_ERASE) begin
          d.fill = FILL_ERASE;
        end else if (ps == PS_NUM3 && (c == CH_SHOW || c == CH_HIDE)) begin
          d.set_shown = (first_num == SHOW_MODE);
          d.shown_val = (c == CH_SHOW);
        end else if (is_digit) begin
          // a number past its limit drops the sequence
          if (fn_prod <= NUM1_LIMIT) begin
            d.fn_we  = 1'b1;
            d.fn_val = fn_prod[6:0];
            d.next   = ps;
          end
        end
      end
      PS_SEMI: begin
        if (is_digit) begin
          d.sn_we  = 1'b1;
          d.sn_val = {4'b0000, digit};
          d.next   = PS_NUM2;
        end
      end
      PS_QUEST: begin
        if (is_digit) begin
          d.fn_we  = 1'b1;
          d.fn_val = {3'b000, digit};
          d.next   = PS_NUM3;
        end
      end
      PS_NUM2: begin
        if (c == CH_HOME) begin
          d.cur = CUR_MOVE;
        end else if (is_digit) begin
          if (sn_prod <= NUM2_LIMIT) begin
            d.sn_we  = 1'b1;
            d.sn_val = sn_prod[7:0];
            d.next   = PS_NUM2;
          end
        end
      end
      PS_PAGE: begin
        if (c == CH_PLUS) begin
          d.set_wrap = 1'b1;
          d.wrap_val = 1'b1;
        end else if (c == CH_STAR) begin
          d.set_wrap = 1'b1;
          d.wrap_val = 1'b0;
        end
      end
      default: begin
        d.next = PS_START;
      end
    endcase
  end

endmodule

### src/text_terminal_escape_engine.sv
// text terminal top level: cell buffer memory, cursor state and sequencer
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  kind, byte_in, read_row, read_column
//  out      from block out_valid / out_stall cell_value, cursor_column, cursor_row,
//                                            cursor_visible, auto_page_on
//  cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// a console byte that moves the cursor or stores one cell is handled in S_EXEC, a cell read
// in S_EXEC and then S_RDATA, as the cell memory read is registered
// a scroll copies each cell up a row through S_SCR_RD and S_SCR_WR, then blanks the bottom
// row in S_FILL; a line or screen clear blanks one cell per cycle in S_FILL
// after reset a clearing pass writes spaces to all 2^(clog2(MAX_COLUMNS)+clog2(MAX_ROWS))
// cells (8192 at the default size), with in_stall high; cfg writes are taken always
// out_stall holds the result and S_DONE; the next item is taken while a result waits
`include "assert_macros.svh"

module text_terminal_escape_engine #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [7:0]                     byte_in,
  input  logic [5:0]                     read_row,
  input  logic [6:0]                     read_column,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     cell_value,
  output logic [6:0]                     cursor_column,
  output logic [5:0]                     cursor_row,
  output logic                           cursor_visible,
  output logic                           auto_page_on,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import tte_pkg::*;

  localparam int XW        = $clog2(MAX_COLUMNS);
  localparam int YW        = $clog2(MAX_ROWS);
  localparam int CW        = XW + 1;
  localparam int RW        = YW + 1;
  localparam int AW        = XW + YW;
  localparam int DEPTH     = 1 << AW;
  localparam int COLS_INIT = (COLS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLS_RESET;
  localparam int ROWS_INIT = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

  eng_state_t   state, state_next;
  parse_state_t ps;
  logic [6:0]   first_num;
  logic [7:0]   second_num;
  logic [XW-1:0] cur_x, nx, x_pre, x_fin;
  logic [YW-1:0] cur_y, ny, y_pre, y_fin;
  logic          shown, wrap, shown_n, wrap_n;
  logic [CW-1:0] cols, cols_cfg, cols_new;
  logic [RW-1:0] rows, rows_cfg, rows_new;

  // accepted item
  logic        item_kind;
  logic [7:0]  item_byte;
  logic [5:0]  item_row;
  logic [6:0]  item_col;

  dec_t dec;

  // cursor datapath
  logic [CW-1:0] xw, x_inc, tab_x, fill_end_n;
  logic [RW-1:0] y_inc;
  logic [9:0]    erase_end;
  logic          go_down, scroll_req, fill_req, fill_more_n;

  // buffer walk counters
  logic [XW-1:0] wx;
  logic [YW-1:0] wy;
  logic [CW-1:0] fx, fend;
  logic [YW-1:0] fy;
  logic          fmore;
  logic          row_done, fy_more, scr_last;
  logic [AW-1:0] clr_addr;

  // cell memory
  logic [7:0]    mem [0:DEPTH-1];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, rd_addr;
  logic [7:0]    mem_wdata, rdata;
  logic [7:0]    rr;
  logic [8:0]    cc;
  logic          rd_ok, rd_miss;

  // result path
  logic        accept, exec_byte, slot_free, load_out, cfg_we;
  logic [7:0]  done_cell, out_cell;
  logic [8:0]  col_ext;
  logic [7:0]  row_ext;
  logic        out_shown, out_wrap;
  logic        cursor_ok;

  tte_decode u_decode (
    .ps         (ps),
    .c          (item_byte),
    .first_num  (first_num),
    .second_num (second_num),
    .d          (dec)
  );

  // handshake terms
  always_comb begin
    accept    = in_valid && !in_stall;
    exec_byte = (state == S_EXEC) && !item_kind;
    slot_free = !out_valid || !out_stall;
    cfg_we    = cfg_valid && cfg_ready;
    cursor_ok = (CW'(cur_x) < cols) && (RW'(cur_y) < rows);
  end

  // cursor movement, scroll and blanking requests of the current byte
  always_comb begin
    nx         = cur_x;
    ny         = cur_y;
    go_down    = 1'b0;
    scroll_req = 1'b0;
    xw         = CW'(cur_x);
    x_inc      = xw + CW'(1);
    tab_x      = (xw + CW'(TAB_STEP)) & ~CW'(TAB_STEP - 1);
    unique case (dec.cur)
      CUR_LEFT: begin
        if (cur_x != '0) begin
          nx = cur_x - XW'(1);
        end else if (cur_y != '0) begin
          nx = XW'(cols - CW'(1));
          ny = cur_y - YW'(1);
        end
      end
      CUR_RIGHT: begin
        if (x_inc >= cols) begin
          nx      = '0;
          go_down = 1'b1;
        end else begin
          nx = XW'(x_inc);
        end
      end
      CUR_TAB: begin
        if (tab_x >= cols) begin
          nx      = '0;
          go_down = 1'b1;
        end else begin
          nx = XW'(tab_x);
        end
      end
      CUR_NEWLINE: begin
        nx      = '0;
        go_down = 1'b1;
      end
      CUR_DOWN: begin
        go_down = 1'b1;
      end
      CUR_UP: begin
        if (cur_y != '0) ny = cur_y - YW'(1);
      end
      CUR_CR: begin
        nx = '0;
      end
      CUR_HOME: begin
        nx = '0;
        ny = '0;
      end
      CUR_MOVE: begin
        // a target outside the screen leaves the cursor alone
        if (second_num != '0 && 9'(second_num) <= 9'(cols) &&
            first_num != '0 && 8'(first_num) <= 8'(rows)) begin
          nx = XW'(second_num - 8'd1);
          ny = YW'(first_num - 7'd1);
        end
      end
      default: begin
        nx = cur_x;
      end
    endcase
    y_inc = RW'(ny) + RW'(1);
    if (go_down) begin
      if (y_inc >= rows) begin
        if (wrap) begin
          ny = '0;
        end else begin
          ny         = YW'(rows - RW'(1));
          scroll_req = 1'b1;
        end
      end else begin
        ny = YW'(y_inc);
      end
    end
    // erase stops at the last column
    erase_end  = 10'(cur_x) + 10'(first_num);
    fill_end_n = cols;
    if (dec.fill == FILL_ERASE && erase_end < 10'(cols)) fill_end_n = CW'(erase_end);
    fill_req    = (dec.fill == FILL_LINE) || (dec.fill == FILL_SCREEN) ||
                  (dec.fill == FILL_ERASE && first_num != '0);
    fill_more_n = (dec.fill == FILL_SCREEN);
    shown_n     = dec.set_shown ? dec.shown_val : shown;
    wrap_n      = dec.set_wrap ? dec.wrap_val : wrap;
  end

  // configuration values and the cursor pulled inside the screen
  always_comb begin
    if (cfg_data == '0) cols_cfg = CW'(1);
    else if (9'(cfg_data) > 9'(MAX_COLUMNS)) cols_cfg = CW'(MAX_COLUMNS);
    else cols_cfg = CW'(cfg_data);
    if (cfg_data[6:0] == '0) rows_cfg = RW'(1);
    else if (8'(cfg_data[6:0]) > 8'(MAX_ROWS)) rows_cfg = RW'(MAX_ROWS);
    else rows_cfg = RW'(cfg_data[6:0]);
    cols_new = (cfg_we && cfg_index == REG_COLUMNS) ? cols_cfg : cols;
    rows_new = (cfg_we && cfg_index == REG_ROWS) ? rows_cfg : rows;
    x_pre    = exec_byte ? nx : cur_x;
    y_pre    = exec_byte ? ny : cur_y;
    x_fin    = (CW'(x_pre) >= cols_new) ? XW'(cols_new - CW'(1)) : x_pre;
    y_fin    = (RW'(y_pre) >= rows_new) ? YW'(rows_new - RW'(1)) : y_pre;
  end

  // walk end conditions and read address of a cell read
  always_comb begin
    row_done = (fx + CW'(1)) >= fend;
    fy_more  = (RW'(fy) + RW'(1)) < rows;
    scr_last = ((CW'(wx) + CW'(1)) >= cols) && ((RW'(wy) + RW'(1)) >= rows);
    rr       = 8'(item_row);
    cc       = 9'(item_col);
    rd_ok    = (rr < 8'(MAX_ROWS)) && (cc < 9'(MAX_COLUMNS));
    rd_addr  = {rr[YW-1:0], cc[XW-1:0]};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (item_kind) state_next = S_RDATA;
        else if (scroll_req) state_next = (rows > RW'(1)) ? S_SCR_RD : S_FILL;
        else if (fill_req) state_next = S_FILL;
        else if (slot_free) state_next = S_IDLE;
        else state_next = S_DONE;
      end
      S_RDATA: begin
        state_next = slot_free ? S_IDLE : S_DONE;
      end
      S_SCR_RD: begin
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        state_next = scr_last ? S_FILL : S_SCR_RD;
      end
      S_FILL: begin
        if (row_done && !(fmore && fy_more)) state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
    endcase
  end

  // memory controls, stall and result loading
  always_comb begin
    in_stall  = (state != S_IDLE);
    cfg_ready = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = {fy, fx[XW-1:0]};
    mem_wdata = CH_SPACE;
    mem_raddr = rd_addr;
    load_out  = 1'b0;
    out_cell  = done_cell;
    out_shown = shown;
    out_wrap  = wrap;
    col_ext   = 9'(cur_x);
    row_ext   = 8'(cur_y);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_EXEC: begin
        mem_we    = !item_kind && dec.put;
        mem_waddr = {cur_y, cur_x};
        mem_wdata = dec.put_val;
        load_out  = !item_kind && !scroll_req && !fill_req && slot_free;
        out_cell  = '0;
        out_shown = shown_n;
        out_wrap  = wrap_n;
        col_ext   = 9'(nx);
        row_ext   = 8'(ny);
      end
      S_RDATA: begin
        load_out = slot_free;
        out_cell = rd_miss ? 8'h00 : rdata;
      end
      S_SCR_RD: begin
        mem_raddr = {wy, wx};
      end
      S_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {wy - YW'(1), wx};
        mem_wdata = rdata;
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_DONE: begin
        load_out = slot_free;
      end
      S_IDLE: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // cell memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      ps         <= PS_START;
      first_num  <= '0;
      second_num <= '0;
      cur_x      <= '0;
      cur_y      <= '0;
      shown      <= 1'b1;
      wrap       <= 1'b0;
      cols       <= CW'(COLS_INIT);
      rows       <= RW'(ROWS_INIT);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (exec_byte) begin
        ps    <= dec.next;
        shown <= shown_n;
        wrap  <= wrap_n;
        if (dec.fn_we) first_num <= dec.fn_val;
        if (dec.sn_we) second_num <= dec.sn_val;
      end
      cur_x <= x_fin;
      cur_y <= y_fin;
      cols  <= cols_new;
      rows  <= rows_new;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // item, walk and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= kind;
      item_byte <= byte_in;
      item_row  <= read_row;
      item_col  <= read_column;
    end
    unique case (state)
      S_EXEC: begin
        rd_miss   <= !rd_ok;
        done_cell <= '0;
        wy        <= YW'(1);
        wx        <= '0;
        if (scroll_req) begin
          // the bottom row is blanked after the copy
          fy    <= YW'(rows - RW'(1));
          fx    <= '0;
          fend  <= cols;
          fmore <= 1'b0;
        end else begin
          fy    <= cur_y;
          fx    <= CW'(cur_x);
          fend  <= fill_end_n;
          fmore <= fill_more_n;
        end
      end
      S_RDATA: begin
        done_cell <= rd_miss ? 8'h00 : rdata;
      end
      S_SCR_WR: begin
        if ((CW'(wx) + CW'(1)) >= cols) begin
          wx <= '0;
          wy <= wy + YW'(1);
        end else begin
          wx <= wx + XW'(1);
        end
      end
      S_FILL: begin
        if (row_done) begin
          fy <= fy + YW'(1);
          fx <= '0;
        end else begin
          fx <= fx + CW'(1);
        end
      end
      S_CLEAR, S_IDLE, S_SCR_RD, S_DONE: begin
        rd_miss <= rd_miss;
      end
    endcase
    if (load_out) begin
      cell_value     <= out_cell;
      cursor_column  <= col_ext[6:0];
      cursor_row     <= row_ext[5:0];
      cursor_visible <= out_shown;
      auto_page_on   <= out_wrap;
    end
  end

  // checks
  `ASSERT_IMP(a_cursor_in_screen, clk, rst, state == S_IDLE, cursor_ok)
  `ASSERT_NXT(a_accept_starts_exec, clk, rst, in_valid && !in_stall, state == S_EXEC)
  `ASSERT_IMP(a_result_source, clk, rst, $rose(out_valid), $past(load_out))
  `ASSERT_IMP(a_scroll_row_nonzero, clk, rst, state == S_SCR_WR, wy != '0)

endmodule
